FILE: rtl/core/pvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants for the prefix varint decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned LEAD_W  = 7;

    // Lead byte class boundaries (lowest code of each class)
    localparam logic [BYTE_W-1:0] LEAD_NEG_MIN = 8'b1111_1000;
    localparam logic [BYTE_W-1:0] LEAD_64_MIN  = 8'b1111_0100;
    localparam logic [BYTE_W-1:0] LEAD_32_MIN  = 8'b1111_0000;
    localparam logic [BYTE_W-1:0] LEAD_28_MIN  = 8'b1110_0000;
    localparam logic [BYTE_W-1:0] LEAD_21_MIN  = 8'b1100_0000;
    localparam logic [BYTE_W-1:0] LEAD_14_MIN  = 8'b1000_0000;

    // Value bits kept from the lead byte
    localparam logic [BYTE_W-1:0] MASK_28 = 8'b0000_1111;
    localparam logic [BYTE_W-1:0] MASK_21 = 8'b0001_1111;
    localparam logic [BYTE_W-1:0] MASK_14 = 8'b0011_1111;
    localparam logic [BYTE_W-1:0] MASK_7  = 8'b0111_1111;

    // Trailing byte counts per class
    localparam logic [COUNT_W-1:0] MORE_64 = 4'd8;
    localparam logic [COUNT_W-1:0] MORE_32 = 4'd4;
    localparam logic [COUNT_W-1:0] MORE_28 = 4'd3;
    localparam logic [COUNT_W-1:0] MORE_21 = 4'd2;
    localparam logic [COUNT_W-1:0] MORE_14 = 4'd1;
    localparam logic [COUNT_W-1:0] MORE_7  = 4'd0;

    // Result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NEG_FORM = 1'b1;

    // Lead byte classification
    typedef struct packed {
        logic               neg;        // unsupported negative form
        logic [COUNT_W-1:0] more;       // trailing bytes expected
        logic [LEAD_W-1:0]  init_bits;  // value bits carried by lead byte
    } lead_info_t;

endpackage

FILE: rtl/core/pvd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_in_if
// Byte stream channel: valid/ready with one encoded byte per transaction.
// ----------------------------------------------------------------------------
interface pvd_in_if;
    logic                       valid;
    logic                       ready;
    logic [pvd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/core/pvd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_out_if
// Result channel: valid/ready with one decoded integer per transaction.
// ----------------------------------------------------------------------------
interface pvd_out_if;
    logic                        valid;
    logic                        ready;
    logic [pvd_pkg::VALUE_W-1:0] value;
    logic [pvd_pkg::COUNT_W-1:0] byte_count;
    logic                        status;

    modport source (output valid, output value, output byte_count, output status,
                    input ready);
    modport sink   (input valid, input value, input byte_count, input status,
                    output ready);
endinterface

FILE: rtl/core/prefix_varint_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_decoder_unit
// Decodes big-endian prefix-coded unsigned varints from a byte stream.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload                         | Transaction
//  ---------+-----+---------------------------------+---------------------------
//  in_ch    | in  | in_byte[7:0]                    | one encoded byte
//  res_ch   | out | value[63:0], byte_count[3:0],   | one decoded integer or
//           |     | status                          | negative-form error
//
//  One byte per cycle while in_ch.ready is high. A result appears in the
//  output register the cycle after the last byte of its integer is taken
//  (after the lead byte for one-byte forms and unsupported negative forms).
//  The single output register holds a result until taken; in_ch.ready drops
//  only while that register is full and res_ch.ready is low.
//  rst_n (async, active low) clears decode state and the output valid bit.
//
// Lead byte forms:
//   0xxxxxxx  7-bit value, 1 byte total
//   10xxxxxx  6 bits + 1 byte
//   110xxxxx  5 bits + 2 bytes
//   1110xxxx  4 bits + 3 bytes
//   111100xx  4-byte value follows (lead bits dropped)
//   111101xx  8-byte value follows (lead bits dropped)
//   11111xxx  unsupported negative form -> value 0, count 1, status 1
// ----------------------------------------------------------------------------
module prefix_varint_decoder_unit
(
    input  logic      clk,
    input  logic      rst_n,
    pvd_in_if.sink    in_ch,
    pvd_out_if.source res_ch
);

    // Decode state
    logic [pvd_pkg::VALUE_W-1:0] accumulator_reg, accumulator_next;
    logic [pvd_pkg::COUNT_W-1:0] bytes_left_reg,  bytes_left_next;
    logic [pvd_pkg::COUNT_W-1:0] total_length_reg, total_length_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [pvd_pkg::VALUE_W-1:0] value_reg;
    logic [pvd_pkg::COUNT_W-1:0] byte_count_reg;
    logic                        status_reg;

    // Result produced by the byte being taken this cycle
    logic                        emit;
    logic [pvd_pkg::VALUE_W-1:0] emit_value;
    logic [pvd_pkg::COUNT_W-1:0] emit_count;
    logic                        emit_status;

    logic                        in_fire;
    logic [pvd_pkg::VALUE_W-1:0] acc_shift;
    pvd_pkg::lead_info_t         lead_info;

    pvd_lead_class u_lead_class
    (
        .lead (in_ch.in_byte),
        .info (lead_info)
    );

    // Take a byte whenever the output slot is free or drains this cycle
    assign in_ch.ready = !out_valid_reg || res_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign acc_shift = {accumulator_reg[pvd_pkg::VALUE_W-pvd_pkg::BYTE_W-1:0],
                        in_ch.in_byte};

    always_comb
    begin
        accumulator_next  = accumulator_reg;
        bytes_left_next   = bytes_left_reg;
        total_length_next = total_length_reg;
        emit              = 1'b0;
        emit_value        = '0;
        emit_count        = '0;
        emit_status       = pvd_pkg::STATUS_OK;

        if (in_fire)
        begin
            if (bytes_left_reg != '0)
            begin
                // continuation byte: shift in, finish on the last one
                accumulator_next = acc_shift;
                bytes_left_next  = bytes_left_reg - 4'd1;
                if (bytes_left_reg == 4'd1)
                begin
                    emit       = 1'b1;
                    emit_value = acc_shift;
                    emit_count = total_length_reg;
                end
            end
            else if (lead_info.neg)
            begin
                accumulator_next  = '0;
                total_length_next = 4'd1;
                emit              = 1'b1;
                emit_count        = 4'd1;
                emit_status       = pvd_pkg::STATUS_NEG_FORM;
            end
            else
            begin
                accumulator_next  = pvd_pkg::VALUE_W'(lead_info.init_bits);
                total_length_next = lead_info.more + 4'd1;
                bytes_left_next   = lead_info.more;
                if (lead_info.more == pvd_pkg::MORE_7)
                begin
                    emit       = 1'b1;
                    emit_value = pvd_pkg::VALUE_W'(lead_info.init_bits);
                    emit_count = 4'd1;
                end
            end
        end

        out_valid_next = emit || (out_valid_reg && !res_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accumulator_reg  <= '0;
            bytes_left_reg   <= '0;
            total_length_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            accumulator_reg  <= accumulator_next;
            bytes_left_reg   <= bytes_left_next;
            total_length_reg <= total_length_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Result payload, loaded only when a new result is produced
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg      <= emit_value;
            byte_count_reg <= emit_count;
            status_reg     <= emit_status;
        end
    end

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.value      = value_reg;
    assign res_ch.byte_count = byte_count_reg;
    assign res_ch.status     = status_reg;

endmodule

FILE: rtl/core/pvd_lead_class.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvd_lead_class
// Classifies a lead byte by its prefix: length and initial value bits.
// ----------------------------------------------------------------------------
module pvd_lead_class
(
    input  logic [pvd_pkg::BYTE_W-1:0] lead,
    output pvd_pkg::lead_info_t        info
);

    logic [pvd_pkg::BYTE_W-1:0] masked;

    always_comb
    begin
        info.neg = 1'b0;
        masked   = '0;
        if (lead >= pvd_pkg::LEAD_NEG_MIN)
        begin
            info.neg  = 1'b1;
            info.more = pvd_pkg::MORE_7;
        end
        else if (lead >= pvd_pkg::LEAD_64_MIN)
        begin
            info.more = pvd_pkg::MORE_64;
        end
        else if (lead >= pvd_pkg::LEAD_32_MIN)
        begin
            info.more = pvd_pkg::MORE_32;
        end
        else if (lead >= pvd_pkg::LEAD_28_MIN)
        begin
            info.more = pvd_pkg::MORE_28;
            masked    = lead & pvd_pkg::MASK_28;
        end
        else if (lead >= pvd_pkg::LEAD_21_MIN)
        begin
            info.more = pvd_pkg::MORE_21;
            masked    = lead & pvd_pkg::MASK_21;
        end
        else if (lead >= pvd_pkg::LEAD_14_MIN)
        begin
            info.more = pvd_pkg::MORE_14;
            masked    = lead & pvd_pkg::MASK_14;
        end
        else
        begin
            info.more = pvd_pkg::MORE_7;
            masked    = lead & pvd_pkg::MASK_7;
        end
        info.init_bits = masked[pvd_pkg::LEAD_W-1:0];
    end

endmodule

FILE: tb/prefix_varint_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_varint_decoder_unit_tb
// Drives encoded byte streams into the varint decoder and scores every
// decoded integer against an in-bench decoder model. A directed pass covers
// the lead byte classes, some at their extremes. Random passes follow, with
// sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module prefix_varint_decoder_unit_tb;

    // Expected transaction on the result channel
    typedef struct packed {
        logic [pvd_pkg::VALUE_W-1:0] value;
        logic [pvd_pkg::COUNT_W-1:0] byte_count;
        logic                        status;
    } result_t;

    // Shapes of generated integers; NOISE is a raw random byte
    typedef enum int {
        FORM_7,
        FORM_14,
        FORM_21,
        FORM_28,
        FORM_32,
        FORM_64,
        FORM_NEG,
        FORM_NOISE
    } form_e;

    localparam int RANDOM_BYTES_PER_PASS = 456;
    localparam int DRAIN_CYCLES          = 8;

    logic clk;
    logic rst_n;

    pvd_in_if  in_ch ();
    pvd_out_if res_ch ();

    prefix_varint_decoder_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .res_ch (res_ch)
    );

    // Decoder model state, mirrors the block's reset values
    logic [pvd_pkg::VALUE_W-1:0] dec_acc;
    logic [pvd_pkg::COUNT_W-1:0] dec_left;
    logic [pvd_pkg::COUNT_W-1:0] dec_len;

    result_t pending_results[$];
    int      error_count;
    int      bytes_sent;
    int      send_idle_pct;
    int      recv_stall_pct;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Decoder model: consume one byte, return 1 when it completes an integer.
    // A byte taken while trailing bytes are owed is data whatever its bits.
    // ------------------------------------------------------------------------
    function automatic bit decode_byte(input logic [pvd_pkg::BYTE_W-1:0] b,
                                       output result_t r);
        logic [pvd_pkg::COUNT_W-1:0] more;
        r = '0;
        if (dec_left != '0)
        begin
            dec_acc  = {dec_acc[pvd_pkg::VALUE_W-pvd_pkg::BYTE_W-1:0], b};
            dec_left = dec_left - 4'd1;
            if (dec_left != '0)
                return 1'b0;
            r.value      = dec_acc;
            r.byte_count = dec_len;
            r.status     = pvd_pkg::STATUS_OK;
            return 1'b1;
        end

        // Negative forms are unsupported: immediate error, next byte is a lead
        if (b >= pvd_pkg::LEAD_NEG_MIN)
        begin
            dec_acc      = '0;
            dec_len      = 4'd1;
            r.value      = '0;
            r.byte_count = 4'd1;
            r.status     = pvd_pkg::STATUS_NEG_FORM;
            return 1'b1;
        end
        else if (b >= pvd_pkg::LEAD_64_MIN)
        begin
            dec_acc = '0;
            more    = pvd_pkg::MORE_64;
        end
        else if (b >= pvd_pkg::LEAD_32_MIN)
        begin
            dec_acc = '0;
            more    = pvd_pkg::MORE_32;
        end
        else if (b >= pvd_pkg::LEAD_28_MIN)
        begin
            dec_acc = pvd_pkg::VALUE_W'(b & pvd_pkg::MASK_28);
            more    = pvd_pkg::MORE_28;
        end
        else if (b >= pvd_pkg::LEAD_21_MIN)
        begin
            dec_acc = pvd_pkg::VALUE_W'(b & pvd_pkg::MASK_21);
            more    = pvd_pkg::MORE_21;
        end
        else if (b >= pvd_pkg::LEAD_14_MIN)
        begin
            dec_acc = pvd_pkg::VALUE_W'(b & pvd_pkg::MASK_14);
            more    = pvd_pkg::MORE_14;
        end
        else
        begin
            dec_acc = pvd_pkg::VALUE_W'(b & pvd_pkg::MASK_7);
            more    = pvd_pkg::MORE_7;
        end

        dec_len  = more + 4'd1;
        dec_left = more;
        if (more != pvd_pkg::MORE_7)
            return 1'b0;
        r.value      = dec_acc;
        r.byte_count = 4'd1;
        r.status     = pvd_pkg::STATUS_OK;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Byte sender. Called at a falling edge; returns at the falling edge after
    // the transaction, with valid still high so back-to-back bytes have no gap.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [pvd_pkg::BYTE_W-1:0] b);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // accepted on this edge
        if (decode_byte(b, r))
            pending_results.push_back(r);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Lower valid and wait for every outstanding result, plus a short tail
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Trailing byte content: mostly random, sometimes all zeros or all ones
    function automatic logic [pvd_pkg::BYTE_W-1:0] fill_byte(input int fill_mode);
        if (fill_mode == 0)
            return 8'h00;
        if (fill_mode == 1)
            return 8'hFF;
        return pvd_pkg::BYTE_W'($urandom_range(255));
    endfunction

    // One well-formed integer of a random shape, or a stray random byte
    task automatic send_random_varint();
        form_e                      form;
        logic [pvd_pkg::BYTE_W-1:0] raw;
        logic [pvd_pkg::BYTE_W-1:0] lead;
        int                         trail;
        int                         fill_mode;
        form      = form_e'($urandom_range(FORM_7, FORM_NOISE));
        fill_mode = $urandom_range(7);
        raw       = (fill_mode == 1) ? 8'hFF : fill_byte(fill_mode);
        case (form)
            FORM_7:
            begin
                lead  = raw & pvd_pkg::MASK_7;
                trail = pvd_pkg::MORE_7;
            end
            FORM_14:
            begin
                lead  = pvd_pkg::LEAD_14_MIN | (raw & pvd_pkg::MASK_14);
                trail = pvd_pkg::MORE_14;
            end
            FORM_21:
            begin
                lead  = pvd_pkg::LEAD_21_MIN | (raw & pvd_pkg::MASK_21);
                trail = pvd_pkg::MORE_21;
            end
            FORM_28:
            begin
                lead  = pvd_pkg::LEAD_28_MIN | (raw & pvd_pkg::MASK_28);
                trail = pvd_pkg::MORE_28;
            end
            FORM_32:
            begin
                // low two lead bits are don't-care
                lead  = pvd_pkg::LEAD_32_MIN | (raw & 8'h03);
                trail = pvd_pkg::MORE_32;
            end
            FORM_64:
            begin
                lead  = pvd_pkg::LEAD_64_MIN | (raw & 8'h03);
                trail = pvd_pkg::MORE_64;
            end
            FORM_NEG:
            begin
                lead  = pvd_pkg::LEAD_NEG_MIN | (raw & 8'h07);
                trail = 0;
            end
            default:
            begin
                lead  = pvd_pkg::BYTE_W'($urandom_range(255));
                trail = 0;
            end
        endcase
        send_byte(lead);
        repeat (trail) send_byte(fill_byte(fill_mode));
    endtask

    task automatic run_random_bytes(input int quota);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < quota)
            send_random_varint();
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every transaction on res_ch must match the oldest
    // expected result, field by field.
    // ------------------------------------------------------------------------
    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result value %h count %0d status %0b",
                     $time, res_ch.value, res_ch.byte_count, res_ch.status);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (res_ch.value !== want.value)
        begin
            $display("%0t: value mismatch: expected %h actual %h",
                     $time, want.value, res_ch.value);
            error_count++;
        end
        if (res_ch.byte_count !== want.byte_count)
        begin
            $display("%0t: byte_count mismatch: expected %0d actual %0d",
                     $time, want.byte_count, res_ch.byte_count);
            error_count++;
        end
        if (res_ch.status !== want.status)
        begin
            $display("%0t: status mismatch: expected %0b actual %0b",
                     $time, want.status, res_ch.status);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            check_result();
    end

    // Receiver back-pressure, updated on the falling edge
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Each lead class, the one-byte form at both extremes, both negative-form
    // ends, and trailing bytes that look like lead bytes.
    task automatic test_directed_forms();
        logic [pvd_pkg::BYTE_W-1:0] stream[] = '{
            8'h00, 8'h7F,                                   // one-byte extremes
            8'hF8, 8'hFF,                                   // negative forms
            8'hBF, 8'hFF,                                   // 6+8 bits, all ones
            8'hC0, 8'hF8, 8'h80,                            // lead-like data bytes
            8'hEF, 8'hFF, 8'h00, 8'hFF,                     // 4+24 bits
            8'hF3, 8'h00, 8'h00, 8'h00, 8'h00,              // 4-byte zero, lead bits set
            8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'hFF,              // 8-byte all ones
                   8'hFF, 8'hFF, 8'hFF, 8'hFF
        };
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (stream[i])
            send_byte(stream[i]);
        drain_results();
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_bytes(RANDOM_BYTES_PER_PASS);
    endtask

    task automatic test_random_sender_gaps();
        send_idle_pct  = 57;
        recv_stall_pct = 0;
        run_random_bytes(RANDOM_BYTES_PER_PASS);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        run_random_bytes(RANDOM_BYTES_PER_PASS);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_random_bytes(RANDOM_BYTES_PER_PASS);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = '0;
        dec_acc        = '0;
        dec_left       = '0;
        dec_len        = '0;
        error_count    = 0;
        bytes_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_forms();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stall();
        test_random_both_idle();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/pvd_pkg.sv
rtl/core/pvd_in_if.sv
rtl/core/pvd_out_if.sv
rtl/core/pvd_lead_class.sv
rtl/core/prefix_varint_decoder_unit.sv
tb/prefix_varint_decoder_unit_tb.sv
